// File: src/unsorted_max_priority_queue_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the unsorted max-priority queue
// Shared property wrappers, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef UNSORTED_MAX_PRIORITY_QUEUE_MACROS_SVH
`define UNSORTED_MAX_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication.
`define UMPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define UMPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/umpq_pkg.sv
// ---------------------------------------------------------------------------
// umpq_pkg
// Widths, command codes and status codes of the unsorted max-priority queue.
// ---------------------------------------------------------------------------
package umpq_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int DATA_W       = 32;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// File: src/unsorted_max_priority_queue.sv
// ---------------------------------------------------------------------------
// unsorted_max_priority_queue
// Max-priority queue kept as an unsorted array in a single-port-read memory.
// ---------------------------------------------------------------------------
// Each command transaction yields exactly one result transaction. Insert
// appends at the end of the store and passes straight to the result state.
// Peek streams every stored entry through one signed comparator, one
// memory read a cycle. Delete-max runs the same scan, then moves the
// entries above the winner down one place through the same read port and
// the single write port. Errors (insert when full, peek or delete when
// empty) and the unused command code return at once with a zero value.
// The block takes one command at a time: in_ready is high only while the
// sequencer is idle, and a finished result waits in the output register
// without holding off the next command.
// The store needs no clearing after reset: only entries below the count are
// ever read.
// ---------------------------------------------------------------------------
module unsorted_max_priority_queue
  import umpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // command channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CMD_W-1:0]           command,
  input  logic signed [DATA_W-1:0]   value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   result_value,
  output logic [STATUS_W-1:0]        status,
  output logic [COUNT_W-1:0]         count
);

  // AW indexes the store; CW holds a fill level up to CAPACITY itself.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;

  state_t                     state;
  logic [CW-1:0]              fill;        // entries held
  logic [CMD_W-1:0]           op;          // command in progress
  logic [CW-1:0]              raddr;       // next address to read
  logic                       rvalid;      // rdata holds entry ridx
  logic [AW-1:0]              ridx;
  logic signed [DATA_W-1:0]   rdata;
  logic [AW-1:0]              best_idx;    // first position of running maximum
  logic signed [DATA_W-1:0]   res_value;   // running maximum, then the result
  logic [STATUS_W-1:0]        res_status;

  logic signed [DATA_W-1:0]   mem [CAPACITY];
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic signed [DATA_W-1:0]   mem_wdata;

  logic                       issue;
  logic                       stream_done;
  logic                       has_room;
  logic                       new_max;
  logic                       out_load;

  assign in_ready    = (state == S_IDLE);
  assign has_room    = (fill < CW'(CAPACITY));

  // Read stream shared by the scan and the shift: one address per cycle.
  assign issue       = ((state == S_SCAN) || (state == S_SHIFT)) && (raddr < fill);
  assign stream_done = !issue && !rvalid;

  // The one comparator: strictly greater keeps the lowest index on ties.
  assign new_max     = rvalid && ((ridx == '0) || (rdata > res_value));

  // A finished result moves into the output register once that is free.
  assign out_load    = (state == S_RESULT) && (!out_valid || out_ready);

  // Write port: append on insert, or move an entry down one place on shift.
  always_comb begin
    if (state == S_SHIFT) begin
      mem_we    = rvalid;
      mem_waddr = ridx - AW'(1);
      mem_wdata = rdata;
    end else begin
      mem_we    = (state == S_IDLE) && in_valid && (command == CMD_INSERT) && has_room;
      mem_waddr = fill[AW-1:0];
      mem_wdata = value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[raddr[AW-1:0]];
  end

  // Sequencer, with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Load a finished result, or drop the held one once the far side takes it.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          rvalid <= 1'b0;
          if (in_valid) begin
            op         <= command;
            raddr      <= '0;
            res_status <= ST_OK;
            case (command)
              CMD_INSERT: begin
                if (has_room) begin
                  fill      <= fill + CW'(1);
                  res_value <= value;
                end else begin
                  res_value  <= '0;
                  res_status <= ST_FULL;
                end
                state <= S_RESULT;
              end
              CMD_PEEK, CMD_DELETE: begin
                if (fill == '0) begin
                  res_value  <= '0;
                  res_status <= ST_EMPTY;
                  state      <= S_RESULT;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                // Unused code: no-op with a zero value.
                res_value <= '0;
                state     <= S_RESULT;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (issue) begin
            raddr <= raddr + CW'(1);
          end
          rvalid <= issue;
          ridx   <= raddr[AW-1:0];
          if (new_max) begin
            res_value <= rdata;
            best_idx  <= ridx;
          end
          if (stream_done) begin
            if (op == CMD_DELETE) begin
              // Close the gap: start reading just above the winner.
              raddr <= CW'(best_idx) + CW'(1);
              state <= S_SHIFT;
            end else begin
              state <= S_RESULT;
            end
          end
        end

        S_SHIFT: begin
          if (issue) begin
            raddr <= raddr + CW'(1);
          end
          rvalid <= issue;
          ridx   <= raddr[AW-1:0];
          if (stream_done) begin
            fill  <= fill - CW'(1);
            state <= S_RESULT;
          end
        end

        S_RESULT: begin
          rvalid <= 1'b0;
          // Hold until the output register is free.
          if (out_load) begin
            result_value <= res_value;
            status       <= res_status;
            count        <= COUNT_W'(fill);
            state        <= S_IDLE;
          end
        end

        default: begin
          rvalid <= 1'b0;
          state  <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/umpq_checker.sv
// ---------------------------------------------------------------------------
// umpq_checker
// Port-level checks on the unsorted max-priority queue, bound to the top.
// ---------------------------------------------------------------------------
`include "unsorted_max_priority_queue_macros.svh"

module umpq_checker
  import umpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] result_value,
  input logic [STATUS_W-1:0]      status,
  input logic [COUNT_W-1:0]       count
);

  // Hold a result until its transaction completes.
  `UMPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped early")

  // One command at a time: ready drops after each accepted transaction.
  `UMPQ_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "ready held after accept")

  // A full report carries a zero value and a full count.
  `UMPQ_ASSERT_NOW(a_full_report, out_valid && (status == ST_FULL),
                   (result_value == '0) && (count == COUNT_W'(CAPACITY)), "bad full report")

  // An empty report carries a zero value and a zero count.
  `UMPQ_ASSERT_NOW(a_empty_report, out_valid && (status == ST_EMPTY),
                   (result_value == '0) && (count == '0), "bad empty report")

endmodule

bind unsorted_max_priority_queue umpq_checker #(.CAPACITY(CAPACITY)) u_umpq_checker (.*);

// File: tb/tb_unsorted_max_priority_queue.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_unsorted_max_priority_queue
// Self-checking bench for the unsorted max-priority queue. A command list is
// built up front: a short directed run over the empty, extreme-value and tied-maximum
// corners, then random phases that fill the queue to capacity, drain it back
// to empty, mix the commands or throw in noise. A clocked driver offers the
// list on the command channel and a clocked monitor predicts each accepted
// command and checks every result transaction against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_unsorted_max_priority_queue;
  import umpq_pkg::*;

  localparam int QUEUE_DEPTH  = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1500;
  localparam int IDLE_PCT     = 22;
  localparam int HOLD_AT      = 300;   // accepted commands before the long stall
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FROM    = 700;   // accepted-command window with no idling
  localparam int CALM_TO      = 950;
  localparam int SETTLE       = 300;   // longer than the slowest delete-max
  localparam int STALL_LIMIT  = 4000;  // cycles with no transaction at all

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] val;
    bit                       wait_drained;  // hold back until nothing is in flight
  } pq_command_t;

  typedef struct {
    logic signed [DATA_W-1:0] val;
    logic [STATUS_W-1:0]      st;
    logic [COUNT_W-1:0]       cnt;
  } pq_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         command   = CMD_INSERT;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;

  unsorted_max_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_value(result_value),
    .status      (status),
    .count       (count)
  );

  // Clock and reset: hold reset at the start, release it on a falling edge.
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // -------------------------------------------------------------------------
  // Queue model: its own copy of the store and the entry count.
  // -------------------------------------------------------------------------
  logic signed [DATA_W-1:0] pq_store [QUEUE_DEPTH];
  int                       pq_count = 0;

  // Apply one command to the model and return the result it must give.
  function automatic pq_result_t pq_apply(logic [CMD_W-1:0] cmd,
                                          logic signed [DATA_W-1:0] val);
    pq_result_t r;
    int         best;
    r.val = '0;
    r.st  = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (pq_count >= QUEUE_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          pq_store[pq_count] = val;
          pq_count++;
          r.val = val;
        end
      end
      CMD_PEEK, CMD_DELETE: begin
        if (pq_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          // First (lowest-index) entry holding the largest signed value wins.
          best = 0;
          for (int i = 1; i < pq_count; i++)
            if (pq_store[i] > pq_store[best]) best = i;
          r.val = pq_store[best];
          if (cmd == CMD_DELETE) begin
            for (int i = best; i + 1 < pq_count; i++) pq_store[i] = pq_store[i + 1];
            pq_count--;
          end
        end
      end
      default: ;  // unused code: no-op, zero value, status ok
    endcase
    r.cnt = pq_count[COUNT_W-1:0];
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Command list. The builder tracks the count the queue will reach, so that
  // phases can steer it to full and back to empty on purpose.
  // -------------------------------------------------------------------------
  pq_command_t pending_q [$];
  pq_result_t  expected_q [$];
  int          plan_count = 0;

  int error_count  = 0;
  int taken_count  = 0;
  int quiet_cycles = 0;
  bit cmd_fire     = 1'b0;

  task automatic plan(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val,
                      bit wait_drained = 1'b0);
    pq_command_t c;
    c.cmd          = cmd;
    c.val          = val;
    c.wait_drained = wait_drained;
    pending_q.push_back(c);
    if (cmd == CMD_INSERT && plan_count < QUEUE_DEPTH) plan_count++;
    if (cmd == CMD_DELETE && plan_count > 0) plan_count--;
  endtask

  // Mix corners, a narrow band that forces tied maxima, and full-range words.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return '0;
        default: return -1;
      endcase
    end
    if (sel < 40) return $signed($urandom_range(16)) - 8;
    return $signed($urandom());
  endfunction

  function automatic logic [CMD_W-1:0] pick_mixed_cmd();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return CMD_INSERT;
    if (sel < 70) return CMD_PEEK;
    if (sel < 95) return CMD_DELETE;
    return CMD_UNUSED;
  endfunction

  initial begin : stimulus
    int random_items;
    int phase;
    int mode;
    int len;
    bit gate;

    // Directed run: empty errors, unused code, extremes, tied maxima.
    plan(CMD_PEEK,   $signed($urandom()));
    plan(CMD_DELETE, $signed($urandom()));
    plan(CMD_UNUSED, $signed($urandom()));
    plan(CMD_INSERT, VAL_MIN);
    plan(CMD_PEEK,   '0);
    plan(CMD_INSERT, VAL_MAX);
    plan(CMD_INSERT, '0);
    plan(CMD_INSERT, VAL_MAX);              // tie with an earlier maximum
    plan(CMD_INSERT, -1);
    plan(CMD_PEEK,   VAL_MAX);
    plan(CMD_UNUSED, VAL_MAX);
    plan(CMD_DELETE, '0);                   // removes the lower-index maximum
    plan(CMD_DELETE, '0);
    plan(CMD_DELETE, '0);
    plan(CMD_DELETE, '0);
    plan(CMD_DELETE, '0);                   // last entry, the minimum
    plan(CMD_DELETE, '0);                   // empty again
    plan(CMD_INSERT, 32'sd5);
    plan(CMD_INSERT, 32'sd3);
    plan(CMD_INSERT, 32'sd5);
    plan(CMD_DELETE, '0);
    plan(CMD_DELETE, '0);
    plan(CMD_DELETE, '0);
    plan(CMD_PEEK,   '0);

    // Random phases. The first one fills the queue so that full is reached
    // early; one later phase is forced to wait for every result.
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      mode = (phase == 0) ? 0 : $urandom_range(9);
      gate = (phase == 4) || ($urandom_range(5) == 0);
      if (mode <= 2) begin
        // fill to capacity, then push against the full queue
        while (plan_count < QUEUE_DEPTH) begin
          plan(($urandom_range(9) == 0) ? CMD_PEEK : CMD_INSERT, pick_value(), gate);
          gate = 1'b0;
          random_items++;
        end
        len = $urandom_range(4, 1);
        repeat (len) begin
          plan(CMD_INSERT, pick_value(), gate);
          gate = 1'b0;
          random_items++;
        end
      end else if (mode <= 5) begin
        // drain to empty, then poke the empty queue
        while (plan_count > 0) begin
          plan(($urandom_range(99) < 85) ? CMD_DELETE : CMD_PEEK, pick_value(), gate);
          gate = 1'b0;
          random_items++;
        end
        len = $urandom_range(3, 1);
        repeat (len) begin
          plan(($urandom_range(1) == 0) ? CMD_DELETE : CMD_PEEK, pick_value(), gate);
          gate = 1'b0;
          random_items++;
        end
      end else if (mode <= 8) begin
        len = $urandom_range(60, 20);
        repeat (len) begin
          plan(pick_mixed_cmd(), pick_value(), gate);
          gate = 1'b0;
          random_items++;
        end
      end else begin
        // noise: any code, any word; the unused code does not count
        len = $urandom_range(15, 5);
        repeat (len) begin
          plan(CMD_W'($urandom_range(3)), $signed($urandom()), gate);
          gate = 1'b0;
          if (pending_q[$].cmd != CMD_UNUSED) random_items++;
        end
      end
      phase++;
    end

    // Wait for the list to go out and every result to come back, then give
    // the block time to show any stray result.
    @(negedge clk);
    while (rst || pending_q.size() != 0 || in_valid || expected_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (error_count == 0)
      $display("tb_unsorted_max_priority_queue passed");
    else
      $display("tb_unsorted_max_priority_queue failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Monitor: sample at the rising edge, predict accepted commands, check
  // results, and watch for a hung handshake.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    pq_result_t want;
    if (rst) begin
      cmd_fire <= 1'b0;
    end else begin
      cmd_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_q.push_back(pq_apply(command, value));
        taken_count++;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected: value %0d status %0d count %0d",
                 result_value, status, count);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (result_value !== want.val) begin
            $error("result_value: expected %0d, got %0d", want.val, result_value);
            error_count++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            error_count++;
          end
          if (count !== want.cnt) begin
            $error("count: expected %0d, got %0d", want.cnt, count);
            error_count++;
          end
        end
      end
      // Count cycles with no transaction on either channel.
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("tb_unsorted_max_priority_queue failed");
          $finish;
        end
      end
    end
  end

  // No idling on either side while this window of commands goes through.
  wire calm = (taken_count >= CALM_FROM) && (taken_count < CALM_TO);

  // -------------------------------------------------------------------------
  // Driver: change inputs at the falling edge. Hold a command until its
  // transaction completes; a gated command waits until nothing is in flight.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    pq_command_t next_cmd;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !cmd_fire) begin
      // hold: the offered command is still waiting for in_ready
    end else if (pending_q.size() == 0 ||
                 (!calm && $urandom_range(99) < IDLE_PCT) ||
                 (pending_q[0].wait_drained && expected_q.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      next_cmd = pending_q.pop_front();
      in_valid <= 1'b1;
      command  <= next_cmd.cmd;
      value    <= next_cmd.val;
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long stall so that a finished
  // result sits in the output register while the sender keeps offering.
  // -------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && taken_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

endmodule
